>>> rtl/shsc_pkg.sv
package shsc_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int MAX_KEY_LEN = 4096;

    localparam int CHAR_W = 7;
    localparam int SUM_W  = 20;
    localparam int CNT_W  = 13;
    localparam int MOD_W  = 11;
    localparam int SLOT_W = 10;
    localparam int LEN_W  = 16;
    localparam int STEP_W = 5;

    localparam logic [CNT_W-1:0] KEY_LIMIT   = CNT_W'(MAX_KEY_LEN);
    localparam logic [MOD_W-1:0] SLOT_LIMIT  = MOD_W'(MAX_SLOTS);
    localparam logic [MOD_W-1:0] SLOT_RESET  = MOD_W'(16);
    localparam logic [LEN_W-1:0] LEN_FULL    = '1;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SUM_W - 1);
    localparam logic [SLOT_W-1:0] LAST_ENTRY = SLOT_W'(MAX_SLOTS - 1);

    localparam logic [4:0] DIGIT_BASE = 5'd10;
    localparam logic [4:0] DIGIT_HIT  = 5'd5;
    localparam logic [1:0] STEP_HIT   = 2'd1;
    localparam logic [1:0] STEP_MISS  = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             ovf;
    } t_key;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } t_back_state;

    // Character code modulo ten through a reciprocal multiply, exact for 7-bit codes.
    function automatic logic [3:0] char_mod10(input logic [CHAR_W-1:0] c);
        logic [14:0]       prod;
        logic [3:0]        quot;
        logic [CHAR_W-1:0] tens;
        logic [CHAR_W-1:0] rem;
        prod = 15'(c) * 15'd205;
        quot = prod[14:11];
        tens = CHAR_W'(quot) * CHAR_W'(10);
        rem  = c - tens;
        return rem[3:0];
    endfunction

endpackage

>>> rtl/shsc_chan_if.sv
interface shsc_char_if;
    logic                          valid;
    logic                          ready;
    logic [shsc_pkg::CHAR_W-1:0]   char_code;
    logic                          last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface shsc_slot_if;
    logic                          valid;
    logic                          ready;
    logic [shsc_pkg::SLOT_W-1:0]   slot_index;
    logic [shsc_pkg::LEN_W-1:0]    slot_length;
    logic                          key_overflow;

    modport source (output valid, output slot_index, output slot_length, output key_overflow,
                    input ready);
    modport sink   (input valid, input slot_index, input slot_length, input key_overflow,
                    output ready);
endinterface

>>> rtl/shsc_front.sv
module shsc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hold,
    shsc_char_if.sink         i_char,
    output logic              o_key_valid,
    input  logic              i_key_ready,
    output shsc_pkg::t_key    o_key
);

    logic [shsc_pkg::SUM_W-1:0] r_sum;
    logic [3:0]                 r_res10;
    logic [shsc_pkg::CNT_W-1:0] r_cnt;

    logic [shsc_pkg::SUM_W-1:0] n_sum;
    logic [3:0]                 n_res10;
    logic [shsc_pkg::CNT_W-1:0] n_cnt;

    logic [3:0] char_digit;
    logic [4:0] t1;
    logic [4:0] t2;
    logic [1:0] inc;
    logic       take;

    assign i_char.ready = !i_hold && i_key_ready;
    assign take         = i_char.valid && i_char.ready;

    always_comb begin
        char_digit = shsc_pkg::char_mod10(i_char.char_code);
        t1 = {1'b0, r_res10} + {1'b0, char_digit};
        if (t1 >= shsc_pkg::DIGIT_BASE) begin
            t1 = t1 - shsc_pkg::DIGIT_BASE;
        end
        inc = (t1 == shsc_pkg::DIGIT_HIT) ? shsc_pkg::STEP_HIT : shsc_pkg::STEP_MISS;
        t2  = t1 + 5'(inc);
        if (t2 >= shsc_pkg::DIGIT_BASE) begin
            t2 = t2 - shsc_pkg::DIGIT_BASE;
        end
        if (r_cnt < shsc_pkg::KEY_LIMIT) begin
            n_sum   = r_sum + shsc_pkg::SUM_W'(i_char.char_code) + shsc_pkg::SUM_W'(inc);
            n_res10 = t2[3:0];
        end else begin
            n_sum   = r_sum;
            n_res10 = r_res10;
        end
        if (r_cnt <= shsc_pkg::KEY_LIMIT) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    assign o_key_valid = take && i_char.last_char;
    assign o_key.sum   = n_sum;
    assign o_key.ovf   = n_cnt > shsc_pkg::KEY_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_res10 <= '0;
            r_cnt   <= '0;
        end else if (take) begin
            if (i_char.last_char) begin
                r_sum   <= '0;
                r_res10 <= '0;
                r_cnt   <= '0;
            end else begin
                r_sum   <= n_sum;
                r_res10 <= n_res10;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

>>> rtl/shsc_queue.sv
module shsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  shsc_pkg::t_key    i_push,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output shsc_pkg::t_key    o_pop
);

    shsc_pkg::t_key r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_fill;
    logic           push;
    logic           pop;

    assign o_push_ready = r_fill != 2'd2;
    assign o_pop_valid  = r_fill != 2'd0;
    assign o_pop        = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/shsc_back.sv
module shsc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [shsc_pkg::MOD_W-1:0]   i_slot_count,
    output logic                         o_clearing,
    input  logic                         i_key_valid,
    output logic                         o_key_ready,
    input  shsc_pkg::t_key               i_key,
    shsc_slot_if.source                  o_slot
);

    shsc_pkg::t_back_state r_state;
    shsc_pkg::t_back_state n_state;

    logic [shsc_pkg::LEN_W-1:0]  mem [shsc_pkg::MAX_SLOTS];
    logic [shsc_pkg::LEN_W-1:0]  r_rdata;

    logic [shsc_pkg::SLOT_W-1:0] r_addr;
    logic [shsc_pkg::SUM_W-1:0]  r_dividend;
    logic [shsc_pkg::SLOT_W-1:0] r_rem;
    logic [shsc_pkg::MOD_W-1:0]  r_mod;
    logic [shsc_pkg::STEP_W-1:0] r_step;
    logic                        r_ovf;

    logic                        r_out_valid;
    logic [shsc_pkg::SLOT_W-1:0] r_out_slot;
    logic [shsc_pkg::LEN_W-1:0]  r_out_len;
    logic                        r_out_ovf;

    logic [shsc_pkg::MOD_W-1:0]  eff_mod;
    logic [shsc_pkg::MOD_W-1:0]  trial;
    logic [shsc_pkg::LEN_W-1:0]  new_len;
    logic                        out_free;
    logic                        mem_we;
    logic [shsc_pkg::SLOT_W-1:0] mem_waddr;
    logic [shsc_pkg::LEN_W-1:0]  mem_wdata;

    always_comb begin
        if (i_slot_count == '0) begin
            eff_mod = shsc_pkg::MOD_W'(1);
        end else if (i_slot_count > shsc_pkg::SLOT_LIMIT) begin
            eff_mod = shsc_pkg::SLOT_LIMIT;
        end else begin
            eff_mod = i_slot_count;
        end
    end

    always_comb begin
        trial = {r_rem, r_dividend[shsc_pkg::SUM_W-1]};
        if (trial >= r_mod) begin
            trial = trial - r_mod;
        end
    end

    assign new_len  = (r_rdata == shsc_pkg::LEN_FULL) ? r_rdata : r_rdata + 1'b1;
    assign out_free = !r_out_valid || o_slot.ready;

    always_comb begin
        n_state     = r_state;
        o_clearing  = 1'b0;
        o_key_ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_rem;
        mem_wdata   = new_len;
        case (r_state)
            shsc_pkg::ST_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = r_addr;
                mem_wdata  = '0;
                if (r_addr == shsc_pkg::LAST_ENTRY) begin
                    n_state = shsc_pkg::ST_IDLE;
                end
            end
            shsc_pkg::ST_IDLE: begin
                o_key_ready = 1'b1;
                if (i_key_valid) begin
                    n_state = shsc_pkg::ST_DIV;
                end
            end
            shsc_pkg::ST_DIV: begin
                if (r_step == shsc_pkg::LAST_STEP) begin
                    n_state = shsc_pkg::ST_READ;
                end
            end
            shsc_pkg::ST_READ: begin
                n_state = shsc_pkg::ST_WRITE;
            end
            shsc_pkg::ST_WRITE: begin
                if (out_free) begin
                    mem_we  = 1'b1;
                    n_state = shsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shsc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == shsc_pkg::ST_READ) begin
            r_rdata <= mem[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (r_state == shsc_pkg::ST_CLEAR) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            shsc_pkg::ST_IDLE: begin
                r_dividend <= i_key.sum;
                r_ovf      <= i_key.ovf;
                r_rem      <= '0;
                r_step     <= '0;
                r_mod      <= eff_mod;
            end
            shsc_pkg::ST_DIV: begin
                r_rem      <= trial[shsc_pkg::SLOT_W-1:0];
                r_dividend <= {r_dividend[shsc_pkg::SUM_W-2:0], 1'b0};
                r_step     <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == shsc_pkg::ST_WRITE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_slot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == shsc_pkg::ST_WRITE && out_free) begin
            r_out_slot <= r_rem;
            r_out_len  <= new_len;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_slot.valid        = r_out_valid;
    assign o_slot.slot_index   = r_out_slot;
    assign o_slot.slot_length  = r_out_len;
    assign o_slot.key_overflow = r_out_ovf;

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shsc_pkg::ST_DIV || r_state == shsc_pkg::ST_READ)
        |-> ({1'b0, r_rem} < r_mod))
        else $error("remainder not below modulus");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != shsc_pkg::ST_CLEAR) |=> (r_state != shsc_pkg::ST_CLEAR))
        else $error("clearing pass entered after it finished");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != '0))
        else $error("result word carries an empty slot count");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shsc_pkg::ST_DIV && r_step != shsc_pkg::LAST_STEP)
        |=> (r_state == shsc_pkg::ST_DIV))
        else $error("division left before its last step");

endmodule

>>> rtl/string_hash_slot_counter.sv
// Hashes keys that arrive one character per word on the input channel and
// counts how many keys land in each slot. A word carries a 7-bit character
// and a last flag; a key ends on the word whose flag is set.
// The output channel gives one word per key: the slot index (hash modulo the
// configured slot count), the slot's occupancy after this key (saturating at
// 65535) and a flag telling that the key ran past the maximum length.
// The slot count lives at byte address 0 of the APB port; write it only
// while no key is in flight.
// The input takes one character per cycle while the queue has room. Each
// finished key goes into a two-entry queue; the back end takes it, runs a
// bit-serial remainder over the 20-bit sum, a memory read and a
// read-modify-write, and then offers the result from its output register.
// It works on one key at a time, so a run of short keys is limited by the
// back end once the queue fills.
// After reset the slot counter memory is cleared one entry a cycle through all
// 1024 entries; the input channel holds ready low meanwhile, while APB
// writes are taken as usual.
// When the receiver stalls, the result waits in the output register, the
// back end holds, the queue fills, and then the input channel drops ready.
module string_hash_slot_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shsc_char_if.sink   i_char,
    shsc_slot_if.source o_slot,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [shsc_pkg::MOD_W-1:0] r_slot_count;

    logic           clearing;
    logic           fk_valid;
    logic           fk_ready;
    shsc_pkg::t_key fk;
    logic           bk_valid;
    logic           bk_ready;
    shsc_pkg::t_key bk;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_slot_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= shsc_pkg::SLOT_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_slot_count <= pwdata[shsc_pkg::MOD_W-1:0];
        end
    end

    shsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_char      (i_char),
        .o_key_valid (fk_valid),
        .i_key_ready (fk_ready),
        .o_key       (fk)
    );

    shsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fk_valid),
        .o_push_ready (fk_ready),
        .i_push       (fk),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop        (bk)
    );

    shsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (r_slot_count),
        .o_clearing   (clearing),
        .i_key_valid  (bk_valid),
        .o_key_ready  (bk_ready),
        .i_key        (bk),
        .o_slot       (o_slot)
    );

endmodule
